### hw/rtl/msre_pkg.sv
// Shared constants, codes and controller/datapath interface types of the register engine.
package msre_pkg;

    // Store sizes
    localparam int HOLDING_COUNT = 64;
    localparam int INPUT_COUNT   = 64;
    localparam int COIL_COUNT    = 200;
    localparam int FRAME_BYTES   = 256;
    localparam int RESP_SIZE     = 256;

    localparam int HOLD_AW  = $clog2(HOLDING_COUNT);
    localparam int INPUT_AW = $clog2(INPUT_COUNT);
    localparam int COIL_AW  = $clog2(COIL_COUNT);
    localparam int REQ_AW   = $clog2(FRAME_BYTES);
    localparam int RESP_AW  = $clog2(RESP_SIZE);
    localparam int IDX_W    = 9;

    // Item commands
    typedef enum logic [1:0] {
        CMD_BYTE = 2'd0,
        CMD_LOAD = 2'd1,
        CMD_PULL = 2'd2,
        CMD_NONE = 2'd3
    } cmd_code_t;

    // Function codes
    localparam logic [7:0] FC_READ_COILS     = 8'h01;
    localparam logic [7:0] FC_READ_HOLDING   = 8'h03;
    localparam logic [7:0] FC_READ_INPUT     = 8'h04;
    localparam logic [7:0] FC_WRITE_COIL     = 8'h05;
    localparam logic [7:0] FC_WRITE_REG      = 8'h06;
    localparam logic [7:0] FC_WRITE_COILS    = 8'h0F;
    localparam logic [7:0] FC_WRITE_REGS     = 8'h10;

    // Exception codes and limits
    localparam logic [7:0]  EXC_ADDRESS    = 8'd2;
    localparam logic [7:0]  EXC_VALUE      = 8'd3;
    localparam logic [7:0]  EXC_FLAG       = 8'h80;
    localparam logic [15:0] COIL_ON_WORD   = 16'hFF00;
    localparam logic [15:0] MAX_READ_REGS  = 16'd125;
    localparam logic [15:0] MAX_WRITE_REGS = 16'd123;
    localparam logic [15:0] MAX_COILS      = 16'd2000;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_HDR_RD,
        OP_HDR_CAP,
        OP_DECIDE,
        OP_FIX,
        OP_MR_RDH,
        OP_MR_RDL,
        OP_MR_WR,
        OP_MC_RD,
        OP_MC_WR,
        OP_RW_RD,
        OP_RW_HI,
        OP_RW_LO,
        OP_RC_RD,
        OP_RC_ACC,
        OP_DONE
    } dp_op_t;

    // Frame handling plan chosen at decode
    typedef enum logic [2:0] {
        PL_NONE,
        PL_FIX,
        PL_MR,
        PL_MC,
        PL_RW,
        PL_RC
    } plan_t;

    typedef struct packed {
        logic   store_byte;
        logic   load_input;
        logic   pull;
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        plan_t plan;
        logic  hdr_last;
        logic  fix_last;
        logic  item_last;
        logic  rc_last;
    } dp_stat_t;

endpackage

### hw/rtl/msre_dp.sv
// Datapath of the register engine: request, table, coil and response stores and their sequencing.
module msre_dp
    import msre_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  dp_cmd_t             cmd,
    output dp_stat_t            stat,
    input  logic [7:0]          frame_byte,
    input  logic                frame_end,
    input  logic [INPUT_AW-1:0] reg_index,
    input  logic [15:0]         reg_value,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_data,
    output logic                result_strobe,
    output logic [7:0]          resp_byte,
    output logic                resp_valid,
    output logic                resp_last
);

    typedef enum logic [1:0] {
        FK_EXC,
        FK_ECHO,
        FK_READ
    } fix_kind_t;

    // Stores
    logic [7:0]  req_mem   [FRAME_BYTES];
    logic [15:0] hold_mem  [HOLDING_COUNT];
    logic [15:0] input_mem [INPUT_COUNT];
    logic [7:0]  resp_mem  [RESP_SIZE];

    logic [HOLDING_COUNT-1:0] hold_vld_reg;
    logic [INPUT_COUNT-1:0]   input_vld_reg;
    logic [COIL_COUNT-1:0]    coil_bits_reg;

    // Control registers
    logic [7:0]        slave_reg;
    logic [REQ_AW:0]   cnt_reg;
    logic [2:0]        hidx_reg;
    logic [2:0]        fidx_reg;
    logic [IDX_W-1:0]  i_reg;
    logic [RESP_AW-1:0] wptr_reg;
    logic [RESP_AW-1:0] len_reg;
    logic [RESP_AW-1:0] cur_reg;
    logic              pend_reg;
    fix_kind_t         fk_reg;
    logic              tsel_reg;
    logic              out_stb_reg;
    logic              out_vld_reg;
    logic              out_last_reg;

    // Payload registers
    logic [7:0]  hdr_reg [6];
    logic [7:0]  f2_reg;
    logic [7:0]  hi_reg;
    logic [7:0]  acc_reg;
    logic [7:0]  rq_q_reg;
    logic        rq_ok_reg;
    logic [15:0] hold_q_reg;
    logic        hold_vq_reg;
    logic [15:0] input_q_reg;
    logic        input_vq_reg;
    logic        coil_q_reg;
    logic [7:0]  resp_q_reg;

    // Combinational
    logic [15:0]       start_w;
    logic [15:0]       qty_w;
    logic [16:0]       sum_w;
    logic [16:0]       idx_w;
    logic [15:0]       i_ext;
    logic [REQ_AW+1:0] rq_addr;
    logic [7:0]        rq_data;
    logic [15:0]       word_w;
    logic              in_qty;
    plan_t             plan_w;
    fix_kind_t         fk_w;
    logic [7:0]        f2_w;
    logic              tsel_w;
    logic              single_hold;
    logic              single_coil;
    logic [7:0]        fix_byte;
    logic              resp_we;
    logic [7:0]        resp_wd;
    logic [7:0]        acc_next;
    logic              hold_we;
    logic [HOLD_AW-1:0] hold_wa;
    logic [15:0]       hold_wd;
    logic              coil_we;
    logic [COIL_AW-1:0] coil_wa;
    logic              coil_wd;
    logic [COIL_AW-1:0] coil_ra;
    logic              pend_ok;
    logic              pull_last;
    logic              frame_go;

    assign cfg_ready = 1'b1;
    assign frame_go  = cmd.store_byte && frame_end;

    // Header fields and loop addressing
    assign start_w = {hdr_reg[2], hdr_reg[3]};
    assign qty_w   = {hdr_reg[4], hdr_reg[5]};
    assign sum_w   = {1'b0, start_w} + {1'b0, qty_w};
    assign i_ext   = {{(16-IDX_W){1'b0}}, i_reg};
    assign idx_w   = {1'b0, start_w} + {1'b0, i_ext};
    assign in_qty  = i_ext < qty_w;
    assign rq_data = rq_ok_reg ? rq_q_reg : 8'd0;
    assign word_w  = tsel_reg ? (input_vq_reg ? input_q_reg : 16'd0)
                              : (hold_vq_reg ? hold_q_reg : 16'd0);

    // Request byte address per operation
    always_comb
    begin
        case (cmd.op)
            OP_HDR_RD: rq_addr = (REQ_AW+2)'(hidx_reg);
            OP_MR_RDH: rq_addr = (REQ_AW+2)'(7) + (REQ_AW+2)'({i_reg, 1'b0});
            OP_MR_RDL: rq_addr = (REQ_AW+2)'(8) + (REQ_AW+2)'({i_reg, 1'b0});
            OP_MC_RD:  rq_addr = (REQ_AW+2)'(7) + (REQ_AW+2)'(i_reg[IDX_W-1:3]);
            default:   rq_addr = '0;
        endcase
    end

    // Decode the request header
    always_comb
    begin
        plan_w      = PL_NONE;
        fk_w        = FK_EXC;
        f2_w        = EXC_VALUE;
        tsel_w      = 1'b0;
        single_hold = 1'b0;
        single_coil = 1'b0;
        if (cnt_reg >= (REQ_AW+1)'(2))
        begin
            case (hdr_reg[1])
                FC_READ_COILS, FC_WRITE_COILS:
                begin
                    plan_w = PL_FIX;
                    if (qty_w == 16'd0 || qty_w > MAX_COILS)
                        f2_w = EXC_VALUE;
                    else if (sum_w > 17'(COIL_COUNT))
                        f2_w = EXC_ADDRESS;
                    else if (hdr_reg[1] == FC_READ_COILS)
                    begin
                        plan_w = PL_RC;
                        fk_w   = FK_READ;
                        f2_w   = 8'((qty_w + 16'd7) >> 3);
                    end
                    else
                    begin
                        plan_w = PL_MC;
                        fk_w   = FK_ECHO;
                        f2_w   = hdr_reg[2];
                    end
                end
                FC_READ_HOLDING, FC_READ_INPUT:
                begin
                    plan_w = PL_FIX;
                    tsel_w = (hdr_reg[1] == FC_READ_INPUT);
                    if (qty_w == 16'd0 || qty_w > MAX_READ_REGS)
                        f2_w = EXC_VALUE;
                    else if (sum_w > (tsel_w ? 17'(INPUT_COUNT) : 17'(HOLDING_COUNT)))
                        f2_w = EXC_ADDRESS;
                    else
                    begin
                        plan_w = PL_RW;
                        fk_w   = FK_READ;
                        f2_w   = {qty_w[6:0], 1'b0};
                    end
                end
                FC_WRITE_COIL:
                begin
                    plan_w = PL_FIX;
                    if (start_w >= 16'(COIL_COUNT))
                        f2_w = EXC_ADDRESS;
                    else
                    begin
                        fk_w        = FK_ECHO;
                        f2_w        = hdr_reg[2];
                        single_coil = 1'b1;
                    end
                end
                FC_WRITE_REG:
                begin
                    plan_w = PL_FIX;
                    if (start_w >= 16'(HOLDING_COUNT))
                        f2_w = EXC_ADDRESS;
                    else
                    begin
                        fk_w        = FK_ECHO;
                        f2_w        = hdr_reg[2];
                        single_hold = 1'b1;
                    end
                end
                FC_WRITE_REGS:
                begin
                    plan_w = PL_FIX;
                    if (qty_w == 16'd0 || qty_w > MAX_WRITE_REGS)
                        f2_w = EXC_VALUE;
                    else if (sum_w > 17'(HOLDING_COUNT))
                        f2_w = EXC_ADDRESS;
                    else
                    begin
                        plan_w = PL_MR;
                        fk_w   = FK_ECHO;
                        f2_w   = hdr_reg[2];
                    end
                end
                default:
                begin
                    plan_w = PL_NONE;
                end
            endcase
        end
    end

    // Fixed response bytes: exception, echo or read header
    always_comb
    begin
        case (fidx_reg)
            3'd0:    fix_byte = (fk_reg == FK_EXC) ? hdr_reg[0] : slave_reg;
            3'd1:    fix_byte = (fk_reg == FK_EXC) ? (hdr_reg[1] | EXC_FLAG) : hdr_reg[1];
            3'd2:    fix_byte = f2_reg;
            3'd3:    fix_byte = hdr_reg[3];
            3'd4:    fix_byte = hdr_reg[4];
            default: fix_byte = hdr_reg[5];
        endcase
    end

    // Response write port
    assign acc_next = acc_reg | (8'(in_qty && coil_q_reg) << i_reg[2:0]);

    always_comb
    begin
        resp_we = 1'b0;
        resp_wd = fix_byte;
        case (cmd.op)
            OP_FIX:
            begin
                resp_we = 1'b1;
            end
            OP_RW_HI:
            begin
                resp_we = 1'b1;
                resp_wd = word_w[15:8];
            end
            OP_RW_LO:
            begin
                resp_we = 1'b1;
                resp_wd = word_w[7:0];
            end
            OP_RC_ACC:
            begin
                resp_we = (i_reg[2:0] == 3'd7);
                resp_wd = acc_next;
            end
            default:
            begin
                resp_we = 1'b0;
            end
        endcase
    end

    // Holding and coil write ports
    always_comb
    begin
        hold_we = 1'b0;
        hold_wa = idx_w[HOLD_AW-1:0];
        hold_wd = {hi_reg, rq_data};
        coil_we = 1'b0;
        coil_wa = idx_w[COIL_AW-1:0];
        coil_wd = rq_data[i_reg[2:0]];
        if (cmd.op == OP_DECIDE)
        begin
            hold_we = single_hold;
            hold_wa = start_w[HOLD_AW-1:0];
            hold_wd = qty_w;
            coil_we = single_coil && (qty_w == COIL_ON_WORD || qty_w == 16'd0);
            coil_wa = start_w[COIL_AW-1:0];
            coil_wd = (qty_w == COIL_ON_WORD);
        end
        else if (cmd.op == OP_MR_WR)
        begin
            hold_we = 1'b1;
        end
        else if (cmd.op == OP_MC_WR)
        begin
            coil_we = 1'b1;
        end
    end

    assign coil_ra = in_qty ? idx_w[COIL_AW-1:0] : '0;

    // Status to the controller
    assign stat.plan      = plan_w;
    assign stat.hdr_last  = (hidx_reg == 3'd5);
    assign stat.fix_last  = (fidx_reg == ((fk_reg == FK_ECHO) ? 3'd5 : 3'd2));
    assign stat.item_last = (i_ext + 16'd1) == qty_w;
    assign stat.rc_last   = (i_reg[2:0] == 3'd7)
                            && ((8'(i_reg[IDX_W-1:3]) + 8'd1) == f2_reg);

    // Pull bookkeeping
    assign pend_ok   = pend_reg && (cur_reg < len_reg);
    assign pull_last = ({1'b0, cur_reg} + 9'd1) >= {1'b0, len_reg};

    // Memory ports
    always_ff @(posedge clk)
    begin
        if (cmd.store_byte && cnt_reg < (REQ_AW+1)'(FRAME_BYTES))
            req_mem[cnt_reg[REQ_AW-1:0]] <= frame_byte;
        rq_q_reg  <= req_mem[rq_addr[REQ_AW-1:0]];
        rq_ok_reg <= rq_addr < (REQ_AW+2)'(cnt_reg);

        if (hold_we)
            hold_mem[hold_wa] <= hold_wd;
        hold_q_reg  <= hold_mem[idx_w[HOLD_AW-1:0]];
        hold_vq_reg <= hold_vld_reg[idx_w[HOLD_AW-1:0]];

        if (cmd.load_input)
            input_mem[reg_index] <= reg_value;
        input_q_reg  <= input_mem[idx_w[INPUT_AW-1:0]];
        input_vq_reg <= input_vld_reg[idx_w[INPUT_AW-1:0]];

        coil_q_reg <= coil_bits_reg[coil_ra];

        if (resp_we)
            resp_mem[wptr_reg] <= resp_wd;
        if (cmd.pull)
            resp_q_reg <= resp_mem[cur_reg];
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_HDR_CAP)
            hdr_reg[hidx_reg] <= rq_data;
        if (cmd.op == OP_DECIDE)
            f2_reg <= f2_w;
        if (cmd.op == OP_MR_RDL)
            hi_reg <= rq_data;
        if (cmd.op == OP_DECIDE)
            acc_reg <= 8'd0;
        else if (cmd.op == OP_RC_ACC)
            acc_reg <= (i_reg[2:0] == 3'd7) ? 8'd0 : acc_next;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_reg     <= 8'd1;
            cnt_reg       <= '0;
            hidx_reg      <= '0;
            fidx_reg      <= '0;
            i_reg         <= '0;
            wptr_reg      <= '0;
            len_reg       <= '0;
            cur_reg       <= '0;
            pend_reg      <= 1'b0;
            fk_reg        <= FK_EXC;
            tsel_reg      <= 1'b0;
            out_stb_reg   <= 1'b0;
            out_vld_reg   <= 1'b0;
            out_last_reg  <= 1'b0;
            hold_vld_reg  <= '0;
            input_vld_reg <= '0;
            coil_bits_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                slave_reg <= cfg_data;

            // collect request bytes, saturating at the store size
            if (cmd.store_byte && cnt_reg < (REQ_AW+1)'(FRAME_BYTES))
                cnt_reg <= cnt_reg + (REQ_AW+1)'(1);
            if (frame_go)
            begin
                hidx_reg <= '0;
                pend_reg <= 1'b0;
                len_reg  <= '0;
                cur_reg  <= '0;
            end

            if (cmd.load_input)
                input_vld_reg[reg_index] <= 1'b1;
            if (hold_we)
                hold_vld_reg[hold_wa] <= 1'b1;
            if (coil_we)
                coil_bits_reg[coil_wa] <= coil_wd;

            if (cmd.op == OP_HDR_CAP)
                hidx_reg <= hidx_reg + 3'd1;

            if (cmd.op == OP_DECIDE)
            begin
                fidx_reg <= '0;
                i_reg    <= '0;
                wptr_reg <= '0;
                fk_reg   <= fk_w;
                tsel_reg <= tsel_w;
            end
            else
            begin
                if (cmd.op == OP_FIX)
                    fidx_reg <= fidx_reg + 3'd1;
                if (cmd.op == OP_MR_WR || cmd.op == OP_MC_WR || cmd.op == OP_RW_LO
                    || cmd.op == OP_RC_ACC)
                    i_reg <= i_reg + IDX_W'(1);
                if (resp_we)
                    wptr_reg <= wptr_reg + RESP_AW'(1);
            end

            // publish the response and reopen the request store
            if (cmd.op == OP_DONE)
            begin
                len_reg  <= wptr_reg;
                pend_reg <= (wptr_reg != '0);
                cur_reg  <= '0;
                cnt_reg  <= '0;
            end

            // hand out one response byte per pull
            out_stb_reg <= cmd.pull;
            if (cmd.pull)
            begin
                out_vld_reg  <= pend_ok;
                out_last_reg <= pend_ok && pull_last;
                if (pend_ok)
                begin
                    cur_reg <= cur_reg + RESP_AW'(1);
                    if (pull_last)
                        pend_reg <= 1'b0;
                end
            end
        end
    end

    assign result_strobe = out_stb_reg;
    assign resp_byte     = out_vld_reg ? resp_q_reg : 8'd0;
    assign resp_valid    = out_vld_reg;
    assign resp_last     = out_last_reg;

endmodule

### hw/rtl/msre_ctrl.sv
// Controller state machine of the register engine: accepts items and sequences frame handling.
module msre_ctrl
    import msre_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] command,
    input  logic       frame_end,
    output logic       busy,
    output dp_cmd_t    cmd,
    input  dp_stat_t   stat
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_HDR_RD,
        S_HDR_CAP,
        S_DECIDE,
        S_FIX,
        S_MR_RDH,
        S_MR_RDL,
        S_MR_WR,
        S_MC_RD,
        S_MC_WR,
        S_RW_RD,
        S_RW_HI,
        S_RW_LO,
        S_RC_RD,
        S_RC_ACC,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    plan_t  plan_reg;
    plan_t  plan_next;
    logic   accept;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    // Item commands to the datapath
    assign cmd.store_byte = accept && (command == CMD_BYTE);
    assign cmd.load_input = accept && (command == CMD_LOAD);
    assign cmd.pull       = accept && (command == CMD_PULL);

    always_comb
    begin
        case (state_reg)
            S_HDR_RD:  cmd.op = OP_HDR_RD;
            S_HDR_CAP: cmd.op = OP_HDR_CAP;
            S_DECIDE:  cmd.op = OP_DECIDE;
            S_FIX:     cmd.op = OP_FIX;
            S_MR_RDH:  cmd.op = OP_MR_RDH;
            S_MR_RDL:  cmd.op = OP_MR_RDL;
            S_MR_WR:   cmd.op = OP_MR_WR;
            S_MC_RD:   cmd.op = OP_MC_RD;
            S_MC_WR:   cmd.op = OP_MC_WR;
            S_RW_RD:   cmd.op = OP_RW_RD;
            S_RW_HI:   cmd.op = OP_RW_HI;
            S_RW_LO:   cmd.op = OP_RW_LO;
            S_RC_RD:   cmd.op = OP_RC_RD;
            S_RC_ACC:  cmd.op = OP_RC_ACC;
            S_DONE:    cmd.op = OP_DONE;
            default:   cmd.op = OP_NONE;
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        plan_next  = plan_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && command == CMD_BYTE && frame_end)
                    state_next = S_HDR_RD;
            end
            S_HDR_RD:  state_next = S_HDR_CAP;
            S_HDR_CAP: state_next = stat.hdr_last ? S_DECIDE : S_HDR_RD;
            S_DECIDE:
            begin
                plan_next = stat.plan;
                case (stat.plan)
                    PL_MR:   state_next = S_MR_RDH;
                    PL_MC:   state_next = S_MC_RD;
                    PL_NONE: state_next = S_DONE;
                    default: state_next = S_FIX;
                endcase
            end
            S_FIX:
            begin
                if (stat.fix_last)
                begin
                    case (plan_reg)
                        PL_RW:   state_next = S_RW_RD;
                        PL_RC:   state_next = S_RC_RD;
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_MR_RDH:  state_next = S_MR_RDL;
            S_MR_RDL:  state_next = S_MR_WR;
            S_MR_WR:   state_next = stat.item_last ? S_FIX : S_MR_RDH;
            S_MC_RD:   state_next = S_MC_WR;
            S_MC_WR:   state_next = stat.item_last ? S_FIX : S_MC_RD;
            S_RW_RD:   state_next = S_RW_HI;
            S_RW_HI:   state_next = S_RW_LO;
            S_RW_LO:   state_next = stat.item_last ? S_DONE : S_RW_RD;
            S_RC_RD:   state_next = S_RC_ACC;
            S_RC_ACC:  state_next = stat.rc_last ? S_DONE : S_RC_RD;
            S_DONE:    state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // Hold state and plan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            plan_reg  <= PL_NONE;
        end
        else
        begin
            state_reg <= state_next;
            plan_reg  <= plan_next;
        end
    end

endmodule

### hw/rtl/modbus_slave_register_engine_top.sv
// Top level of the Modbus slave register engine: controller plus datapath.
//
// Usage: an item is taken on a rising edge with start high and busy low.
// command selects the item: a request byte (frame_byte, frame_end marks the
// last one), an input-register load (reg_index, reg_value) or a pull of the
// next response byte. The byte marked frame_end starts frame handling and
// raises busy for header fetch, decode and finish, plus exception or single
// write: 3 or 6 response bytes, one per cycle; read registers: 3 bytes,
// then a read and two writes per register; read coils: 3 bytes, then a read
// and an accumulate per coil bit rounded up to whole bytes; write
// registers: two reads and a write per register, then 6 bytes; write coils:
// a read and a write per coil, then 6 bytes. These come from the single
// request memory read port and the one response memory write port. A pull
// is answered in the next cycle: result_strobe is high for one cycle with
// resp_byte/resp_valid/resp_last; pulls may come every cycle while busy is
// low. The receiver cannot stall the result. The config channel (cfg_valid,
// cfg_ready, cfg_data) writes the station address, always ready.
// Reset: station address 1, all tables read as zero, nothing pending; no
// clearing pass is needed, so items are taken right after reset.
module modbus_slave_register_engine_top
    import msre_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          command,
    input  logic [7:0]          frame_byte,
    input  logic                frame_end,
    input  logic [INPUT_AW-1:0] reg_index,
    input  logic [15:0]         reg_value,
    output logic                result_strobe,
    output logic [7:0]          resp_byte,
    output logic                resp_valid,
    output logic                resp_last,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    msre_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .command   (command),
        .frame_end (frame_end),
        .busy      (busy),
        .cmd       (cmd),
        .stat      (stat)
    );

    msre_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .frame_byte    (frame_byte),
        .frame_end     (frame_end),
        .reg_index     (reg_index),
        .reg_value     (reg_value),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .result_strobe (result_strobe),
        .resp_byte     (resp_byte),
        .resp_valid    (resp_valid),
        .resp_last     (resp_last)
    );

`ifndef SYNTH
    // a result only follows a pull transaction
    a_strobe_after_pull: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(start && !busy && command == CMD_PULL))
        else $error("result without pull");

    // frame handling starts only on the last request byte
    a_busy_on_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && command == CMD_BYTE && frame_end))
        else $error("busy without frame end");

    // empty pulls give all-zero results
    a_empty_pull_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !resp_valid) |-> (resp_byte == 8'd0 && !resp_last))
        else $error("nonzero empty pull");

    // a pull is never taken while a frame is being handled
    a_no_pull_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !result_strobe)
        else $error("result during frame handling");
`endif

endmodule
